FILE: sv/nsf_pkg.sv
// ----------------------------------------------------------------------------
// NMEA sentence framer package
// Shared types, character codes and sentence type tables for the framer.
// ----------------------------------------------------------------------------
package nsf_pkg;

  typedef enum logic [4:0] {
    PH_HUNT = 5'b00001,
    PH_ADDR = 5'b00010,
    PH_DATA = 5'b00100,
    PH_SUM1 = 5'b01000,
    PH_SUM2 = 5'b10000
  } nsf_phase_t;

  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_ACCEPTED = 2'd1;
  localparam logic [1:0] KIND_MISMATCH = 2'd2;
  localparam logic [1:0] KIND_DROPPED  = 2'd3;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam int NUM_TYPES = 4;
  localparam int TYPE_LEN  = 5;

  localparam logic [2:0] TYPE_GPGGA = 3'd0;
  localparam logic [2:0] TYPE_GPGSA = 3'd1;
  localparam logic [2:0] TYPE_GPGSV = 3'd2;
  localparam logic [2:0] TYPE_GPRMC = 3'd3;
  localparam logic [2:0] TYPE_OTHER = 3'd4;

  typedef struct packed {
    logic       valid;
    logic       channel;
    logic [7:0] rx_byte;
  } nsf_item_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic       channel;
    logic [7:0] payload_byte;
    logic [8:0] payload_count;
    logic [2:0] sentence_type;
    logic [7:0] computed_sum;
  } nsf_result_t;

  // Character of a known address word at a given position.
  function automatic logic [7:0] type_char(input logic [1:0] t, input logic [2:0] k);
    logic [7:0] ch;
    ch = 8'h00;
    case (k)
      3'd0: ch = "G";
      3'd1: ch = "P";
      3'd2: begin
        if (t == TYPE_GPRMC[1:0]) ch = "R";
        else ch = "G";
      end
      3'd3: begin
        if (t == TYPE_GPGGA[1:0]) ch = "G";
        else if (t == TYPE_GPRMC[1:0]) ch = "M";
        else ch = "S";
      end
      3'd4: begin
        if (t == TYPE_GPGSV[1:0]) ch = "V";
        else if (t == TYPE_GPRMC[1:0]) ch = "C";
        else ch = "A";
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

FILE: sv/nsf_in_reg.sv
// ----------------------------------------------------------------------------
// NMEA sentence framer input register
// Holds one accepted request until the framer core can process it.
// ----------------------------------------------------------------------------
module nsf_in_reg import nsf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      in_channel,
  input  logic [7:0] in_rx_byte,
  input  logic      advance,
  output nsf_item_t item
);

  logic       valid_r;
  logic       channel_r;
  logic [7:0] rx_byte_r;
  logic       load;

  assign load     = advance || !valid_r;
  assign in_stall = !load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      channel_r <= in_channel;
      rx_byte_r <= in_rx_byte;
    end
  end

  assign item.valid   = valid_r;
  assign item.channel = channel_r;
  assign item.rx_byte = rx_byte_r;

endmodule

FILE: sv/nsf_core.sv
// ----------------------------------------------------------------------------
// NMEA sentence framer core
// Per-channel framing state and the combinational step that updates it.
// ----------------------------------------------------------------------------
module nsf_core import nsf_pkg::*; #(
  parameter int MAX_ADDRESS_LEN = 8,
  parameter int MAX_PAYLOAD_LEN = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        advance,
  input  nsf_item_t   item,
  output nsf_result_t result
);

  localparam int AW = $clog2(MAX_ADDRESS_LEN);
  localparam int IW = $clog2(MAX_PAYLOAD_LEN + 1);

  nsf_phase_t           phase_r [2];
  logic [IW-1:0]        idx_r   [2];
  logic [7:0]           sum_r   [2];
  logic [3:0]           hi_r    [2];
  logic [AW-1:0]        alen_r  [2];
  logic [NUM_TYPES-1:0] match_r [2];

  nsf_phase_t           phase_cur, phase_nxt;
  logic [IW-1:0]        idx_cur, idx_nxt, idx_inc;
  logic [7:0]           sum_cur, sum_nxt;
  logic [3:0]           hi_cur, hi_nxt;
  logic [AW-1:0]        alen_cur, alen_nxt;
  logic [NUM_TYPES-1:0] match_cur, match_nxt, match_upd;
  logic [7:0]           c;
  logic [3:0]           nib;
  logic                 emit;
  logic [1:0]           kind;
  logic [7:0]           pbyte;
  logic [IW+8:0]        idx_ext;
  logic [2:0]           stype;
  logic                 write;

  assign c         = item.rx_byte;
  assign phase_cur = phase_r[item.channel];
  assign idx_cur   = idx_r[item.channel];
  assign sum_cur   = sum_r[item.channel];
  assign hi_cur    = hi_r[item.channel];
  assign alen_cur  = alen_r[item.channel];
  assign match_cur = match_r[item.channel];
  assign nib       = (c <= CH_NINE) ? c[3:0] : c[3:0] + 4'd9;
  assign idx_inc   = idx_cur + 1'b1;
  assign write     = advance && item.valid;

  always_comb begin
    for (int t = 0; t < NUM_TYPES; t++) begin
      match_upd[t] = match_cur[t] && (c == type_char(2'(t), alen_cur[2:0]));
    end
  end

  always_comb begin
    phase_nxt = phase_cur;
    idx_nxt   = idx_cur;
    sum_nxt   = sum_cur;
    hi_nxt    = hi_cur;
    alen_nxt  = alen_cur;
    match_nxt = match_cur;
    emit      = 1'b0;
    kind      = KIND_PAYLOAD;
    pbyte     = 8'h00;
    unique case (phase_cur)
      PH_HUNT: begin
        if (c == CH_DOLLAR) begin
          sum_nxt   = 8'h00;
          idx_nxt   = '0;
          alen_nxt  = '0;
          match_nxt = '1;
          phase_nxt = PH_ADDR;
        end
      end
      PH_ADDR: begin
        if (c == CH_COMMA) begin
          sum_nxt   = sum_cur ^ c;
          idx_nxt   = '0;
          phase_nxt = PH_DATA;
        end else if (c == CH_STAR) begin
          idx_nxt   = '0;
          phase_nxt = PH_SUM1;
        end else begin
          sum_nxt = sum_cur ^ c;
          if (alen_cur < AW'(TYPE_LEN)) begin
            match_nxt = match_upd;
          end
          if ((AW+1)'(alen_cur) + 1'b1 >= (AW+1)'(MAX_ADDRESS_LEN)) begin
            alen_nxt  = '0;
            idx_nxt   = '0;
            phase_nxt = PH_HUNT;
            emit      = 1'b1;
            kind      = KIND_DROPPED;
          end else begin
            alen_nxt = alen_cur + 1'b1;
          end
        end
      end
      PH_DATA: begin
        if (c == CH_STAR) begin
          phase_nxt = PH_SUM1;
        end else if (c == CH_CR) begin
          phase_nxt = PH_HUNT;
          emit      = 1'b1;
          kind      = KIND_ACCEPTED;
        end else begin
          sum_nxt = sum_cur ^ c;
          idx_nxt = idx_inc;
          emit    = 1'b1;
          if (idx_inc >= IW'(MAX_PAYLOAD_LEN)) begin
            phase_nxt = PH_HUNT;
            kind      = KIND_DROPPED;
          end else begin
            kind  = KIND_PAYLOAD;
            pbyte = c;
          end
        end
      end
      PH_SUM1: begin
        hi_nxt    = nib;
        phase_nxt = PH_SUM2;
      end
      PH_SUM2: begin
        phase_nxt = PH_HUNT;
        emit      = 1'b1;
        kind      = (sum_cur == {hi_cur, nib}) ? KIND_ACCEPTED : KIND_MISMATCH;
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
  end

  always_comb begin
    stype = TYPE_OTHER;
    if (alen_nxt == AW'(TYPE_LEN)) begin
      for (int t = NUM_TYPES - 1; t >= 0; t--) begin
        if (match_nxt[t]) stype = 3'(t);
      end
    end
  end

  assign idx_ext = (IW+9)'(idx_nxt);

  assign result.valid         = item.valid && emit;
  assign result.kind          = kind;
  assign result.channel       = item.channel;
  assign result.payload_byte  = pbyte;
  assign result.payload_count = idx_ext[8:0];
  assign result.sentence_type = stype;
  assign result.computed_sum  = sum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        phase_r[i] <= PH_HUNT;
        idx_r[i]   <= '0;
        sum_r[i]   <= 8'h00;
        alen_r[i]  <= '0;
        match_r[i] <= '0;
      end
    end else if (write) begin
      phase_r[item.channel] <= phase_nxt;
      idx_r[item.channel]   <= idx_nxt;
      sum_r[item.channel]   <= sum_nxt;
      alen_r[item.channel]  <= alen_nxt;
      match_r[item.channel] <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (write) begin
      hi_r[item.channel] <= hi_nxt;
    end
  end

endmodule

FILE: sv/nmea_sentence_framer_unit.sv
// ----------------------------------------------------------------------------
// NMEA sentence framer
// Two-channel NMEA 0183 framer with XOR checksum check and sentence typing.
// ----------------------------------------------------------------------------
// A request is held in the input register and its result in the result register.
// Throughput: one request per cycle, on either channel, when not stalled by
// out_stall, set by the single registered pass through the framer core.
// Reset: synchronous, active low; both channels return to hunting for the
// start character and the input and result registers are emptied.
module nmea_sentence_framer_unit import nsf_pkg::*; #(
  parameter int MAX_ADDRESS_LEN = 8,
  parameter int MAX_PAYLOAD_LEN = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_channel,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic       out_channel,
  output logic [7:0] out_payload_byte,
  output logic [8:0] out_payload_count,
  output logic [2:0] out_sentence_type,
  output logic [7:0] out_computed_sum
);

  nsf_item_t   item;
  nsf_result_t result;
  nsf_result_t out_r;
  logic        out_valid_r;
  logic        advance;

  assign advance = !out_valid_r || !out_stall;

  nsf_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_channel (in_channel),
    .in_rx_byte (in_rx_byte),
    .advance    (advance),
    .item       (item)
  );

  nsf_core #(
    .MAX_ADDRESS_LEN (MAX_ADDRESS_LEN),
    .MAX_PAYLOAD_LEN (MAX_PAYLOAD_LEN)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      out_r <= result;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_r.kind;
  assign out_channel       = out_r.channel;
  assign out_payload_byte  = out_r.payload_byte;
  assign out_payload_count = out_r.payload_count;
  assign out_sentence_type = out_r.sentence_type;
  assign out_computed_sum  = out_r.computed_sum;

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NMEA sentence framer testbench
// Drives interleaved NMEA character streams on both channels with random
// request and result pacing, predicts each framer result with an in-bench
// model of the framing state machine, and compares every result field.
// ----------------------------------------------------------------------------
module tb_top;
  import nsf_pkg::*;

  localparam int ADDR_LIMIT    = 8;
  localparam int PAYLOAD_LIMIT = 256;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 200;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_ITEMS  = 500;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  typedef struct packed {
    logic [1:0] kind;
    logic       chan;
    logic [7:0] pbyte;
    logic [8:0] count;
    logic [2:0] stype;
    logic [7:0] sum;
  } frame_event_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_channel;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] out_kind;
  logic       out_channel;
  logic [7:0] out_payload_byte;
  logic [8:0] out_payload_count;
  logic [2:0] out_sentence_type;
  logic [7:0] out_computed_sum;

  nsf_phase_t link_phase [2];
  int         data_count [2];
  logic [7:0] xor_sum [2];
  logic [7:0] rx_sum [2];
  logic [7:0] addr_buf [2][ADDR_LIMIT];
  int         addr_len [2];

  frame_event_t expected_q[$];
  logic [7:0]   frame_q[$];
  logic [7:0]   stream0[$];
  logic [7:0]   stream1[$];
  logic [7:0]   frame_sum;

  int error_count;
  int checked_count;
  int sent_items;
  int live_items;
  int cycle_count;
  int kind_seen [4];
  int tx_gap_pct;
  int rx_stall_pct;
  bit hold_request;

  nmea_sentence_framer_unit #(
    .MAX_ADDRESS_LEN(ADDR_LIMIT),
    .MAX_PAYLOAD_LEN(PAYLOAD_LIMIT)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_channel(in_channel),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_channel(out_channel),
    .out_payload_byte(out_payload_byte),
    .out_payload_count(out_payload_count),
    .out_sentence_type(out_sentence_type),
    .out_computed_sum(out_computed_sum)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    if (c <= CH_NINE) d = c - CH_ZERO;
    else d = c - CH_UPPER_A + 8'd10;
    return d[3:0];
  endfunction

  function automatic logic [2:0] sentence_class(input logic ch);
    logic [39:0] word;
    if (addr_len[ch] != 5) return TYPE_OTHER;
    word = {addr_buf[ch][0], addr_buf[ch][1], addr_buf[ch][2], addr_buf[ch][3],
            addr_buf[ch][4]};
    case (word)
      "GPGGA": return TYPE_GPGGA;
      "GPGSA": return TYPE_GPGSA;
      "GPGSV": return TYPE_GPGSV;
      "GPRMC": return TYPE_GPRMC;
      default: return TYPE_OTHER;
    endcase
  endfunction

  function automatic frame_event_t make_event(input logic ch, input logic [1:0] kind,
                                              input logic [7:0] pbyte);
    frame_event_t ev;
    ev.kind  = kind;
    ev.chan  = ch;
    ev.pbyte = pbyte;
    ev.count = 9'(data_count[ch]);
    ev.stype = sentence_class(ch);
    ev.sum   = xor_sum[ch];
    return ev;
  endfunction

  // Advances one channel of the framer by one character.
  function automatic bit frame_step(input logic ch, input logic [7:0] c,
                                    output frame_event_t ev);
    ev = '0;
    case (link_phase[ch])
      PH_HUNT: begin
        if (c == CH_DOLLAR) begin
          xor_sum[ch] = 8'h00;
          data_count[ch] = 0;
          addr_len[ch] = 0;
          link_phase[ch] = PH_ADDR;
        end
        return 1'b0;
      end
      PH_ADDR: begin
        if (c == CH_COMMA) begin
          xor_sum[ch] ^= c;
          data_count[ch] = 0;
          link_phase[ch] = PH_DATA;
          return 1'b0;
        end
        if (c == CH_STAR) begin
          data_count[ch] = 0;
          link_phase[ch] = PH_SUM1;
          return 1'b0;
        end
        if (addr_len[ch] < ADDR_LIMIT) addr_buf[ch][addr_len[ch]] = c;
        xor_sum[ch] ^= c;
        if (addr_len[ch] + 1 >= ADDR_LIMIT) begin
          addr_len[ch] = 0;
          data_count[ch] = 0;
          link_phase[ch] = PH_HUNT;
          ev = make_event(ch, KIND_DROPPED, 8'h00);
          return 1'b1;
        end
        addr_len[ch]++;
        return 1'b0;
      end
      PH_DATA: begin
        if (c == CH_STAR) begin
          link_phase[ch] = PH_SUM1;
          return 1'b0;
        end
        if (c == CH_CR) begin
          link_phase[ch] = PH_HUNT;
          ev = make_event(ch, KIND_ACCEPTED, 8'h00);
          return 1'b1;
        end
        xor_sum[ch] ^= c;
        data_count[ch]++;
        if (data_count[ch] >= PAYLOAD_LIMIT) begin
          link_phase[ch] = PH_HUNT;
          ev = make_event(ch, KIND_DROPPED, 8'h00);
          return 1'b1;
        end
        ev = make_event(ch, KIND_PAYLOAD, c);
        return 1'b1;
      end
      PH_SUM1: begin
        rx_sum[ch] = {hex_value(c), 4'h0};
        link_phase[ch] = PH_SUM2;
        return 1'b0;
      end
      PH_SUM2: begin
        rx_sum[ch] = rx_sum[ch] | {4'h0, hex_value(c)};
        link_phase[ch] = PH_HUNT;
        ev = make_event(ch, (xor_sum[ch] == rx_sum[ch]) ? KIND_ACCEPTED : KIND_MISMATCH,
                        8'h00);
        return 1'b1;
      end
      default: begin
        link_phase[ch] = PH_HUNT;
        return 1'b0;
      end
    endcase
    return 1'b0;
  endfunction

  task automatic send_byte(input logic ch, input logic [7:0] c);
    frame_event_t ev;
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_channel <= ch;
    in_rx_byte <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
    if (link_phase[ch] != PH_HUNT || c == CH_DOLLAR) live_items++;
    if (frame_step(ch, c, ev)) expected_q.push_back(ev);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_streams();
    logic ch;
    while (stream0.size() + stream1.size() != 0) begin
      if (stream0.size() == 0) ch = 1'b1;
      else if (stream1.size() == 0) ch = 1'b0;
      else ch = 1'($urandom_range(0, 1));
      if (ch) send_byte(1'b1, stream1.pop_front());
      else send_byte(1'b0, stream0.pop_front());
    end
  endtask

  function automatic logic [39:0] known_word(input logic [2:0] t);
    case (t)
      TYPE_GPGGA: return "GPGGA";
      TYPE_GPGSA: return "GPGSA";
      TYPE_GPGSV: return "GPGSV";
      default: return "GPRMC";
    endcase
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return CH_ZERO + 8'(n);
    return (lower ? CH_LOWER_A : CH_UPPER_A) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] data_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == CH_STAR || c == CH_CR) c ^= 8'h40;
    return c;
  endfunction

  task automatic begin_frame();
    frame_q.push_back(CH_DOLLAR);
    frame_sum = 8'h00;
  endtask

  task automatic put_summed(input logic [7:0] c);
    frame_q.push_back(c);
    frame_sum ^= c;
  endtask

  task automatic put_word(input logic [39:0] w);
    int k;
    for (k = 0; k < 5; k++) put_summed(w[39 - 8 * k -: 8]);
  endtask

  task automatic put_checksum(input logic [7:0] flip);
    logic [7:0] v;
    bit         lower;
    v = frame_sum ^ flip;
    lower = 1'($urandom_range(0, 1));
    frame_q.push_back(hex_char(v[7:4], lower));
    frame_q.push_back(hex_char(v[3:0], lower));
  endtask

  task automatic commit_frame(input logic ch);
    foreach (frame_q[i]) begin
      if (ch) stream1.push_back(frame_q[i]);
      else stream0.push_back(frame_q[i]);
    end
    frame_q.delete();
  endtask

  task automatic compose_random_sentence();
    int r;
    int n;
    int k;
    logic [7:0] c;
    if ($urandom_range(0, 99) < 30) begin
      n = $urandom_range(1, 4);
      for (k = 0; k < n; k++) begin
        c = 8'($urandom_range(0, 255));
        if (c == CH_DOLLAR) c = 8'h25;
        frame_q.push_back(c);
      end
    end
    begin_frame();
    r = $urandom_range(0, 99);
    if (r < 60) begin
      put_word(known_word(3'($urandom_range(0, 3))));
    end else if (r < 70) begin
      put_word(known_word(3'($urandom_range(0, 3))) ^ (40'h1 << (8 * $urandom_range(0, 4))));
    end else begin
      n = (r < 92) ? $urandom_range(0, ADDR_LIMIT - 1)
                   : $urandom_range(ADDR_LIMIT, ADDR_LIMIT + 2);
      for (k = 0; k < n; k++) begin
        if ($urandom_range(0, 9) == 0) c = 8'($urandom_range(0, 255));
        else c = CH_UPPER_A + 8'($urandom_range(0, 25));
        put_summed(c);
      end
    end
    if ($urandom_range(0, 99) < 85) begin
      put_summed(CH_COMMA);
      if ($urandom_range(0, 99) == 0) n = $urandom_range(PAYLOAD_LIMIT - 6, PAYLOAD_LIMIT + 2);
      else n = $urandom_range(0, 24);
      for (k = 0; k < n; k++) begin
        if ($urandom_range(0, 19) == 0) put_summed(8'($urandom_range(0, 255)));
        else put_summed(data_char());
      end
    end
    r = $urandom_range(0, 99);
    if (r < 65) begin
      frame_q.push_back(CH_STAR);
      put_checksum(8'h00);
    end else if (r < 78) begin
      frame_q.push_back(CH_STAR);
      put_checksum(8'h01 << $urandom_range(0, 7));
    end else if (r < 90) begin
      frame_q.push_back(CH_CR);
    end else if (r < 96) begin
      frame_q.push_back(CH_STAR);
      frame_q.push_back(8'($urandom_range(0, 255)));
      frame_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic compare_field(input string name, input logic [8:0] want_v,
                               input logic [8:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    frame_event_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0h channel %0h",
                 $time, out_kind, out_channel);
        error_count++;
      end else begin
        want = expected_q.pop_front();
        checked_count++;
        kind_seen[want.kind]++;
        compare_field("kind", 9'(want.kind), 9'(out_kind));
        compare_field("channel", 9'(want.chan), 9'(out_channel));
        compare_field("payload_byte", 9'(want.pbyte), 9'(out_payload_byte));
        compare_field("payload_count", want.count, out_payload_count);
        compare_field("sentence_type", 9'(want.stype), 9'(out_sentence_type));
        compare_field("computed_sum", 9'(want.sum), 9'(out_computed_sum));
      end
    end
  end

  initial begin : rx_pacing
    int k;
    int n;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
        out_stall <= 1'b0;
        hold_request = 1'b0;
      end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 12);
        for (k = 0; k < n; k++) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("nmea_sentence_framer_unit verification failed");
      $finish;
    end
  end

  task automatic test_directed_sentences();
    int k;
    tx_gap_pct = 25;
    rx_stall_pct = 25;
    frame_q.push_back(8'h00);
    frame_q.push_back(8'hFF);
    commit_frame(1'b1);
    frame_q.push_back(CH_STAR);
    commit_frame(1'b0);
    // A carriage return inside the address is an address character, and a
    // start mark inside the data is just data.
    begin_frame();
    put_summed(CH_UPPER_A);
    put_summed(CH_CR);
    put_summed(CH_UPPER_A + 8'd1);
    put_summed(CH_COMMA);
    put_summed(CH_DOLLAR);
    put_summed(8'hFF);
    put_summed(8'h00);
    frame_q.push_back(CH_CR);
    commit_frame(1'b1);
    begin_frame();
    put_word(known_word(TYPE_GPGGA));
    frame_q.push_back(CH_STAR);
    put_checksum(8'h80);
    commit_frame(1'b0);
    begin_frame();
    for (k = 0; k < ADDR_LIMIT; k++) put_summed(CH_UPPER_A + 8'(k));
    commit_frame(1'b1);
    send_streams();
    wait_drained();
  endtask

  task automatic test_payload_overflow();
    int k;
    begin_frame();
    put_word(known_word(TYPE_GPRMC));
    put_summed(CH_COMMA);
    for (k = 0; k < PAYLOAD_LIMIT; k++) put_summed(data_char());
    commit_frame(1'b0);
    begin_frame();
    put_word(known_word(TYPE_GPGSA));
    put_summed(CH_COMMA);
    for (k = 0; k < PAYLOAD_LIMIT - 1; k++) put_summed(data_char());
    frame_q.push_back(CH_STAR);
    put_checksum(8'h00);
    commit_frame(1'b1);
    send_streams();
    wait_drained();
  endtask

  task automatic test_receiver_hold();
    int k;
    tx_gap_pct = 0;
    rx_stall_pct = 0;
    hold_request = 1'b1;
    begin_frame();
    put_word(known_word(TYPE_GPGSV));
    put_summed(CH_COMMA);
    for (k = 0; k < 60; k++) put_summed(data_char());
    frame_q.push_back(CH_STAR);
    put_checksum(8'h00);
    commit_frame(1'b0);
    send_streams();
    wait_drained();
  endtask

  task automatic test_random_streams();
    int goal;
    goal = live_items + RANDOM_ITEMS;
    while (live_items < goal) begin
      if ($urandom_range(0, 5) == 0) begin
        tx_gap_pct = 5 * $urandom_range(0, 7);
        rx_stall_pct = 5 * $urandom_range(0, 7);
      end
      if ($urandom_range(0, 4) != 0) begin
        compose_random_sentence();
        commit_frame(1'b0);
      end
      if ($urandom_range(0, 4) != 0) begin
        compose_random_sentence();
        commit_frame(1'b1);
      end
      send_streams();
    end
    wait_drained();
  endtask

  task automatic test_unpaced_tail();
    int k;
    tx_gap_pct = 0;
    rx_stall_pct = 0;
    for (k = 0; k < 12; k++) begin
      compose_random_sentence();
      commit_frame(1'b0);
      compose_random_sentence();
      commit_frame(1'b1);
      send_streams();
    end
    wait_drained();
  endtask

  initial begin
    int c;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_channel <= 1'b0;
    in_rx_byte <= 8'h00;
    hold_request = 1'b0;
    for (c = 0; c < 2; c++) begin
      link_phase[c] = PH_HUNT;
      data_count[c] = 0;
      xor_sum[c] = 8'h00;
      rx_sum[c] = 8'h00;
      addr_len[c] = 0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_sentences();
    test_payload_overflow();
    test_receiver_hold();
    test_random_streams();
    test_unpaced_tail();
    $display("Drove %0d characters on two channels, %0d of them ignored while hunting.",
             sent_items, sent_items - live_items);
    $display("Checked %0d results: %0d data bytes, %0d accepted, %0d bad checksum, %0d dropped.",
             checked_count, kind_seen[KIND_PAYLOAD], kind_seen[KIND_ACCEPTED],
             kind_seen[KIND_MISMATCH], kind_seen[KIND_DROPPED]);
    if (error_count == 0) begin
      $display("nmea_sentence_framer_unit verification clean");
    end else begin
      $display("nmea_sentence_framer_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/nsf_pkg.sv
sv/nsf_in_reg.sv
sv/nsf_core.sv
sv/nmea_sentence_framer_unit.sv
dv/tb_top.sv
